### rtl/bqpt_pkg.sv
// ----------------------------------------------------------------------------
// bqpt_pkg
// Fixed-point types, coefficient table and rounding helpers for the
// band-pass biquad cascade and peak tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bqpt_pkg;

	localparam int COEF_W  = 24;  // Q3.20
	localparam int DELAY_W = 32;  // Q11.20
	localparam int FRAC    = 20;
	localparam int PROD_W  = COEF_W + DELAY_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int RND_W   = ACC_W - FRAC;
	localparam int SAT_W   = 40;

	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [DELAY_W-1:0] delay_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	// coefficient select codes
	localparam logic [2:0] CS_B0 = 3'd0;
	localparam logic [2:0] CS_B1 = 3'd1;
	localparam logic [2:0] CS_B2 = 3'd2;
	localparam logic [2:0] CS_A1 = 3'd3;
	localparam logic [2:0] CS_A2 = 3'd4;

	localparam coef_t ONE_Q = 24'sd1048576;
	localparam coef_t TWO_Q = 24'sd2097152;

	// a terms are stored negated; section indices ten and above pass the signal through
	function automatic coef_t coef(input logic [3:0] sec, input logic [2:0] sel);
		coef_t b0, b1, b2, a1, a2;
		coef_t c;
		b0 = ONE_Q;
		b1 = 24'sd0;
		b2 = 24'sd0;
		a1 = 24'sd0;
		a2 = 24'sd0;
		unique case (sec)
			4'd0: begin
				b0 = 24'sd807912;  b1 = -24'sd1615824; b2 = 24'sd807912;
				a1 = 24'sd1964863; a2 = -24'sd920557;
			end
			4'd1: begin
				b1 = -TWO_Q; b2 = ONE_Q; a1 = 24'sd1976696; a2 = -24'sd932415;
			end
			4'd2: begin
				b1 = -TWO_Q; b2 = ONE_Q; a1 = 24'sd1999583; a2 = -24'sd955351;
			end
			4'd3: begin
				b1 = -TWO_Q; b2 = ONE_Q; a1 = 24'sd2031935; a2 = -24'sd987772;
			end
			4'd4: begin
				b1 = TWO_Q; b2 = ONE_Q; a1 = -24'sd2064843; a2 = -24'sd1016522;
			end
			4'd5: begin
				b1 = TWO_Q; b2 = ONE_Q; a1 = -24'sd2067943; a2 = -24'sd1019622;
			end
			4'd6: begin
				b1 = TWO_Q; b2 = ONE_Q; a1 = -24'sd2073859; a2 = -24'sd1025540;
			end
			4'd7: begin
				b1 = -TWO_Q; b2 = ONE_Q; a1 = 24'sd2071301; a2 = -24'sd1027223;
			end
			4'd8: begin
				b1 = TWO_Q; b2 = ONE_Q; a1 = -24'sd2082050; a2 = -24'sd1033731;
			end
			4'd9: begin
				b1 = TWO_Q; b2 = ONE_Q; a1 = -24'sd2091756; a2 = -24'sd1043438;
			end
			default: begin
			end
		endcase
		unique case (sel)
			CS_B0:   c = b0;
			CS_B1:   c = b1;
			CS_B2:   c = b2;
			CS_A1:   c = a1;
			CS_A2:   c = a2;
			default: c = 24'sd0;
		endcase
		return c;
	endfunction

	// round to Q.20, half up
	function automatic logic signed [RND_W-1:0] round_frac(input acc_t a);
		acc_t t;
		t = a + (ACC_W'(1) <<< (FRAC - 1));
		return t[ACC_W-1:FRAC];
	endfunction

	function automatic delay_t sat_delay(input logic signed [SAT_W-1:0] v);
		delay_t r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[DELAY_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/bqpt_ram.sv
// ----------------------------------------------------------------------------
// bqpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bqpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 20
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/biquad_bandpass_peak_tracker_top.sv
// ----------------------------------------------------------------------------
// biquad_bandpass_peak_tracker_top
// Band-pass biquad cascade on a shared multiplier with block peak tracking.
// ----------------------------------------------------------------------------
// One sample in, one result out. The sample runs through SECTIONS transposed
// direct-form-II biquads whose d1/d2 delays live in a small RAM; a single
// registered multiplier works through five products per section in the
// six-step read-multiply-writeback sequence that each section runs.
// The next sample is taken as soon as the previous one has reached the
// result register. filtered is saturated to SAMPLE_BITS; block_peak holds
// the largest |filtered| of the block on the item marked end_of_block and is
// zero otherwise. Delays start at zero after reset and persist across blocks.
`default_nettype none

module biquad_bandpass_peak_tracker_top #(
	parameter int SECTIONS    = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                          end_of_block,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic signed [SAMPLE_BITS-1:0]      filtered,
	output logic [SAMPLE_BITS-2:0]             block_peak,
	output logic                               is_last
);

	localparam int DEPTH  = 2 * SECTIONS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int UPSH   = (SAMPLE_BITS <= 21) ? 21 - SAMPLE_BITS : 0;
	localparam int DNSH   = (SAMPLE_BITS > 21) ? SAMPLE_BITS - 21 : 0;
	localparam int OW     = bqpt_pkg::DELAY_W + DNSH + 1;
	localparam int RND    = (UPSH > 0) ? (1 << (UPSH - 1)) : 0;
	localparam logic signed [OW-1:0] SMAX = OW'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [OW-1:0] SMIN = -SMAX - OW'(1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_B0   = 3'd1;
	localparam logic [2:0] ST_B1   = 3'd2;
	localparam logic [2:0] ST_A1   = 3'd3;
	localparam logic [2:0] ST_B2   = 3'd4;
	localparam logic [2:0] ST_A2   = 3'd5;
	localparam logic [2:0] ST_D2W  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]            state_q;
	logic [SEC_W-1:0]      sec_q;
	logic                  last_q;
	bqpt_pkg::delay_t      x_q;
	bqpt_pkg::delay_t      yo_q;
	bqpt_pkg::delay_t      d2_q;
	bqpt_pkg::prod_t       prod_q;
	bqpt_pkg::acc_t        acc_q;
	logic [DEPTH-1:0]      dvalid_q;
	logic                  rd_valid_q;
	logic [SAMPLE_BITS-2:0] peak_q;

	logic                  in_xfer;
	logic                  out_xfer;
	logic                  res_load;
	logic                  last_sec;
	logic [ADDR_W-1:0]     addr_d1;
	logic [ADDR_W-1:0]     addr_d2;
	logic [ADDR_W-1:0]     raddr;
	logic [ADDR_W-1:0]     waddr;
	logic                  ram_we;
	bqpt_pkg::delay_t      wdata;
	logic [bqpt_pkg::DELAY_W-1:0] rdata;
	bqpt_pkg::delay_t      rd_masked;
	logic [2:0]            csel;
	bqpt_pkg::coef_t       mcoef;
	bqpt_pkg::delay_t      mop;
	bqpt_pkg::acc_t        acc_y;
	bqpt_pkg::delay_t      y_sec;
	bqpt_pkg::delay_t      d1_new;
	bqpt_pkg::delay_t      d2_new;
	bqpt_pkg::delay_t      x_conv;
	logic signed [OW-1:0]  yw;
	logic signed [SAMPLE_BITS-1:0] y_out;
	logic [SAMPLE_BITS-1:0] y_neg;
	logic [SAMPLE_BITS-2:0] mag;
	logic [SAMPLE_BITS-2:0] peak_new;

	assign sample_stall = (state_q != ST_IDLE);
	assign in_xfer      = sample_valid && !sample_stall;
	assign out_xfer     = result_valid && !result_stall;
	assign res_load     = (state_q == ST_OUT) && (!result_valid || !result_stall);
	assign last_sec     = (sec_q == SEC_W'(SECTIONS - 1));
	assign addr_d1      = ADDR_W'({sec_q, 1'b0});
	assign addr_d2      = ADDR_W'({sec_q, 1'b1});

	// input scaled to Q11.20
	assign x_conv = (32'(sample) <<< UPSH) >>> DNSH;

	// ram access: d1 read in b0 step, d2 read in b1 step
	assign raddr  = (state_q == ST_B1) ? addr_d2 : addr_d1;
	assign ram_we = (state_q == ST_A2) || (state_q == ST_D2W);
	assign waddr  = (state_q == ST_D2W) ? addr_d2 : addr_d1;
	assign wdata  = (state_q == ST_D2W) ? d2_new : d1_new;
	// entries not yet written since reset read as zero
	assign rd_masked = rd_valid_q ? bqpt_pkg::delay_t'(rdata) : '0;

	bqpt_ram #(
		.WIDTH(bqpt_pkg::DELAY_W),
		.DEPTH(DEPTH)
	) u_delay_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		unique case (state_q)
			ST_B1:   csel = bqpt_pkg::CS_B1;
			ST_A1:   csel = bqpt_pkg::CS_A1;
			ST_B2:   csel = bqpt_pkg::CS_B2;
			ST_A2:   csel = bqpt_pkg::CS_A2;
			default: csel = bqpt_pkg::CS_B0;
		endcase
	end

	assign mcoef = bqpt_pkg::coef(4'(sec_q), csel);
	assign mop   = ((state_q == ST_A1) || (state_q == ST_A2)) ? yo_q : x_q;

	// section arithmetic
	assign acc_y  = bqpt_pkg::ACC_W'(prod_q)
		+ (bqpt_pkg::ACC_W'(rd_masked) <<< bqpt_pkg::FRAC);
	assign y_sec  = bqpt_pkg::sat_delay(bqpt_pkg::SAT_W'(bqpt_pkg::round_frac(acc_y)));
	assign d1_new = bqpt_pkg::sat_delay(bqpt_pkg::SAT_W'(bqpt_pkg::round_frac(acc_q))
		+ bqpt_pkg::SAT_W'(d2_q));
	assign d2_new = bqpt_pkg::sat_delay(bqpt_pkg::SAT_W'(
		bqpt_pkg::round_frac(acc_q + bqpt_pkg::ACC_W'(prod_q))));

	// back to sample scale, saturated
	always_comb begin
		yw = ((OW'(x_q) <<< DNSH) + OW'(RND)) >>> UPSH;
		if (yw > SMAX) begin
			yw = SMAX;
		end else if (yw < SMIN) begin
			yw = SMIN;
		end
		y_out = yw[SAMPLE_BITS-1:0];
		y_neg = -y_out;
		if (!y_out[SAMPLE_BITS-1]) begin
			mag = y_out[SAMPLE_BITS-2:0];
		end else if (y_neg[SAMPLE_BITS-1]) begin
			// most negative value: magnitude clips
			mag = '1;
		end else begin
			mag = y_neg[SAMPLE_BITS-2:0];
		end
		peak_new = (mag > peak_q) ? mag : peak_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sec_q      <= '0;
			dvalid_q   <= '0;
			rd_valid_q <= 1'b0;
			peak_q     <= '0;
		end else begin
			rd_valid_q <= dvalid_q[raddr];
			if (ram_we) begin
				dvalid_q[waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_B0;
						sec_q   <= '0;
					end
				end
				ST_B0:  state_q <= ST_B1;
				ST_B1:  state_q <= ST_A1;
				ST_A1:  state_q <= ST_B2;
				ST_B2:  state_q <= ST_A2;
				ST_A2:  state_q <= ST_D2W;
				ST_D2W: begin
					if (last_sec) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_B0;
						sec_q   <= sec_q + SEC_W'(1);
					end
				end
				ST_OUT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
						peak_q  <= last_q ? '0 : peak_new;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mcoef * mop;
		if (in_xfer) begin
			x_q    <= x_conv;
			last_q <= end_of_block;
		end
		unique case (state_q)
			ST_B1:  yo_q  <= y_sec;
			ST_A1: begin
				acc_q <= bqpt_pkg::ACC_W'(prod_q);
				d2_q  <= rd_masked;
			end
			ST_B2:  acc_q <= acc_q + bqpt_pkg::ACC_W'(prod_q);
			ST_A2:  acc_q <= bqpt_pkg::ACC_W'(prod_q);
			ST_D2W: x_q   <= yo_q;
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (res_load) begin
			result_valid <= 1'b1;
		end else if (out_xfer) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			filtered   <= y_out;
			block_peak <= last_q ? peak_new : '0;
			is_last    <= last_q;
		end
	end

	// a transfer starts the first section
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_B0) && (sec_q == '0))
		else $error("accepted sample did not start the cascade");

	// delays are only written in the two writeback steps
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_A2 || state_q == ST_D2W))
		else $error("delay ram written outside writeback");

	// peak is reported only on the last item of a block
	a_peak_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !is_last) |-> (block_peak == '0))
		else $error("peak reported on a non-last item");

	// running peak clears once the block is closed
	a_peak_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && last_q) |=> (peak_q == '0))
		else $error("running peak not cleared at block end");

endmodule

`default_nettype wire
